// ===== rtl/mrr_pkg.sv =====
package mrr_pkg;

    localparam int RX_BUFFER_BYTES = 256;
    localparam int IDX_W           = $clog2(RX_BUFFER_BYTES + 1);
    localparam int CMP_W           = ((IDX_W > 9) ? IDX_W : 9) + 1;
    localparam int FLEN_W          = 9;
    localparam int TDATA_BITS      = 3 + 8 + 16 + FLEN_W + 16 + 16;
    localparam int M_TDATA_W       = ((TDATA_BITS + 7) / 8) * 8;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0]  ADDR_RESET  = 8'h01;
    localparam logic [15:0] TICKS_RESET = 16'd10;

    localparam logic [7:0] FC_READ_COILS      = 8'd1;
    localparam logic [7:0] FC_READ_INPUTS     = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
    localparam logic [7:0] FC_READ_INPUT_REGS = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
    localparam logic [7:0] FC_WRITE_REG       = 8'd6;
    localparam logic [7:0] FC_WRITE_MULTI     = 8'd16;

    localparam logic [IDX_W-1:0] WRITE_FRAME_LAST = IDX_W'(7);

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        STAT_IDLE    = 3'd0,
        STAT_OK      = 3'd1,
        STAT_CRC_ERR = 3'd2,
        STAT_TIMEOUT = 3'd3,
        STAT_DISCARD = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        REG_EXPECTED_ADDRESS = 1'b0,
        REG_INTERCHAR_TICKS  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0]  expected_address;
        logic [15:0] interchar_ticks;
    } cfg_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [15:0]       timeouts;
        logic [15:0]       crc_errors;
        logic [FLEN_W-1:0] frame_length;
        logic [15:0]       reg_data;
        logic [7:0]        function_code;
        status_t           status;
    } result_t;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/mrr_framer.sv =====
module mrr_framer
    import mrr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]       head_reg [4];
    logic [7:0]       head_next [4];
    logic [7:0]       byte_four_reg, byte_four_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       tail_reg [2];
    logic [7:0]       tail_next [2];
    logic             timer_running_reg, timer_running_next;
    logic [15:0]      timer_count_reg, timer_count_next;
    logic [15:0]      crc_err_cnt_reg, crc_err_cnt_next;
    logic [15:0]      timeout_cnt_reg, timeout_cnt_next;

    logic [IDX_W-1:0] idx_new;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] read_limit;
    logic [15:0]      crc_base;
    logic [15:0]      cnt_inc;
    logic [15:0]      rx_crc;
    logic [7:0]       code;
    logic             is_read;
    logic             is_write;
    logic             done;

    always_comb begin
        byte_index_next    = byte_index_reg;
        head_next          = head_reg;
        byte_four_next     = byte_four_reg;
        crc_next           = crc_reg;
        tail_next          = tail_reg;
        timer_running_next = timer_running_reg;
        timer_count_next   = timer_count_reg;
        crc_err_cnt_next   = crc_err_cnt_reg;
        timeout_cnt_next   = timeout_cnt_reg;
        result             = '0;
        result.status      = STAT_IDLE;
        idx_new            = byte_index_reg + IDX_W'(1);
        idx_ext            = CMP_W'(idx_new);
        crc_base           = (byte_index_reg == '0) ? CRC_INIT : crc_reg;
        cnt_inc            = timer_count_reg + 16'd1;
        rx_crc             = {item.rx_byte, tail_reg[1]};
        code               = 8'h00;
        is_read            = 1'b0;
        is_write           = 1'b0;
        read_limit         = '0;
        done               = 1'b0;

        if (item.operation == OP_TICK) begin
            if (timer_running_reg) begin
                timer_count_next = cnt_inc;
                if (cnt_inc >= cfg.interchar_ticks) begin
                    byte_index_next    = '0;
                    timer_running_next = 1'b0;
                    timer_count_next   = '0;
                    crc_next           = CRC_INIT;
                    timeout_cnt_next   = timeout_cnt_reg + 16'd1;
                    result.status      = STAT_TIMEOUT;
                end
            end
        end else begin
            timer_count_next   = '0;
            timer_running_next = 1'b1;
            if (byte_index_reg >= IDX_W'(RX_BUFFER_BYTES)) begin
                byte_index_next    = '0;
                timer_running_next = 1'b0;
                crc_next           = CRC_INIT;
                result.status      = STAT_DISCARD;
            end else if (byte_index_reg == '0 && item.rx_byte != cfg.expected_address) begin
                result.status = STAT_IDLE;
            end else begin
                if (byte_index_reg < IDX_W'(4)) begin
                    head_next[byte_index_reg[1:0]] = item.rx_byte;
                end
                if (byte_index_reg == IDX_W'(4)) begin
                    byte_four_next = item.rx_byte;
                end
                crc_next = (byte_index_reg >= IDX_W'(2)) ?
                           crc16_feed(crc_base, tail_reg[0]) : crc_base;
                tail_next[0]    = tail_reg[1];
                tail_next[1]    = item.rx_byte;
                byte_index_next = idx_new;

                code       = head_next[1];
                is_read    = (code >= FC_READ_COILS) && (code <= FC_READ_INPUT_REGS);
                is_write   = (code == FC_WRITE_COIL) || (code == FC_WRITE_REG) ||
                             (code == FC_WRITE_MULTI);
                read_limit = CMP_W'(4) + CMP_W'(head_next[2]);
                done       = (is_read && idx_ext > read_limit) ||
                             (is_write && idx_new > WRITE_FRAME_LAST);

                if (idx_new > IDX_W'(3)) begin
                    if (done) begin
                        result.function_code = code;
                        result.frame_length  = idx_ext[FLEN_W-1:0];
                        if (crc_next == rx_crc) begin
                            result.status = STAT_OK;
                            if (code == FC_READ_COILS || code == FC_READ_INPUTS) begin
                                result.reg_data = {8'h00, head_next[3]};
                            end else begin
                                result.reg_data = {head_next[3], byte_four_next};
                            end
                        end else begin
                            result.status    = STAT_CRC_ERR;
                            crc_err_cnt_next = crc_err_cnt_reg + 16'd1;
                        end
                        byte_index_next    = '0;
                        timer_running_next = 1'b0;
                        timer_count_next   = '0;
                        crc_next           = CRC_INIT;
                    end else if (!is_read && !is_write) begin
                        byte_index_next    = '0;
                        timer_running_next = 1'b0;
                        timer_count_next   = '0;
                        crc_next           = CRC_INIT;
                        result.status      = STAT_DISCARD;
                    end
                end
            end
        end

        result.crc_errors = crc_err_cnt_next;
        result.timeouts   = timeout_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg    <= '0;
            byte_four_reg     <= '0;
            crc_reg           <= CRC_INIT;
            tail_reg[0]       <= '0;
            tail_reg[1]       <= '0;
            timer_running_reg <= 1'b0;
            timer_count_reg   <= '0;
            crc_err_cnt_reg   <= '0;
            timeout_cnt_reg   <= '0;
        end else if (step_en) begin
            byte_index_reg    <= byte_index_next;
            byte_four_reg     <= byte_four_next;
            crc_reg           <= crc_next;
            tail_reg          <= tail_next;
            timer_running_reg <= timer_running_next;
            timer_count_reg   <= timer_count_next;
            crc_err_cnt_reg   <= crc_err_cnt_next;
            timeout_cnt_reg   <= timeout_cnt_next;
        end
    end

    // frame head bytes are always written before use
    always_ff @(posedge aclk) begin
        if (step_en) begin
            head_reg <= head_next;
        end
    end

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_index_reg <= IDX_W'(RX_BUFFER_BYTES))
        else $error("byte index past buffer");

    a_timer_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !timer_running_reg |-> timer_count_reg == 16'd0)
        else $error("timer counting while stopped");

    a_frame_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_index_reg != '0 |-> timer_running_reg)
        else $error("frame in progress without timer");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && result.status != STAT_IDLE |=> byte_index_reg == '0)
        else $error("frame not restarted after final status");

    a_crc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && result.status == STAT_CRC_ERR |=>
        crc_err_cnt_reg == $past(crc_err_cnt_reg) + 16'd1)
        else $error("crc error count not advanced");

endmodule

// ===== rtl/modbus_rtu_response_receiver.sv =====
// Modbus RTU master receive framer.
// Input stream: one word per received serial byte or timer tick. s_tuser
// says which (0 byte, 1 tick); s_tdata[7:0] carries the byte.
// Output stream: exactly one result word per input word, in order. The status
// field reports idle/busy, frame ok, crc error, timeout abort or discard;
// function code and frame length are valid on ok/crc error, register data on
// ok only, zero otherwise. Running crc error and timeout counters ride on every word.
// Config port: cfg_wr_en with cfg_index 0 sets the expected slave address,
// index 1 the inter-character tick limit. Write only while idle.
// The input word passes through the input register, then through the framer/crc
// logic into the result register that drives m_tvalid and m_tdata; a stall on
// m_tready holds it in between. Throughput: one word per cycle while m_tready
// is high, set by the combinational byte-wide crc update and frame decode.
// Reset (aresetn low, synchronous) empties both registers, clears frame state
// and counters, and loads address 1 and tick limit 10.
// When m_tready is low the result register holds; one more word can sit in the
// input register, after which s_tready drops until results drain.
module modbus_rtu_response_receiver
    import mrr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [0:0]           cfg_index,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // rx_byte
    input  logic                 s_tuser,   // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[2:0], function_code[10:3], reg_data[26:11], frame_length[35:27],
    // crc_errors[51:36], timeouts[67:52], zero pad above
    output logic [M_TDATA_W-1:0] m_tdata
);

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t result;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_result_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_address <= ADDR_RESET;
            cfg_reg.interchar_ticks  <= TICKS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_EXPECTED_ADDRESS: cfg_reg.expected_address <= cfg_wdata[7:0];
                REG_INTERCHAR_TICKS:  cfg_reg.interchar_ticks  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.operation <= op_t'(s_tuser);
            in_item_reg.rx_byte   <= s_tdata;
        end
        if (advance) begin
            out_result_reg <= result;
        end
    end

    mrr_framer u_framer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

endmodule

// ===== bench/tb_modbus_rtu_response_receiver.sv =====
`timescale 1ns / 100ps

import mrr_pkg::*;

function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    repeat (8) begin
        if (v[0]) begin
            v = (v >> 1) ^ CRC_POLY;
        end else begin
            v = v >> 1;
        end
    end
    return v;
endfunction

class rx_frame_scoreboard;
    logic [7:0]  addr_cfg;
    logic [15:0] ticks_cfg;

    logic [8:0]  idx;
    logic [7:0]  head [4];
    logic [7:0]  byte4;
    logic [15:0] crc_lag;
    logic [7:0]  tail [2];
    bit          tmr_on;
    logic [15:0] tmr_cnt;
    logic [15:0] crc_err_cnt;
    logic [15:0] to_cnt;

    result_t     expected_q[$];
    int          mismatches;
    int          n_checked, n_ok, n_crc, n_to, n_disc;

    function new();
        addr_cfg    = ADDR_RESET;
        ticks_cfg   = TICKS_RESET;
        foreach (head[k]) head[k] = 8'h00;
        byte4       = 8'h00;
        tail[0]     = 8'h00;
        tail[1]     = 8'h00;
        crc_err_cnt = 16'h0000;
        to_cnt      = 16'h0000;
        mismatches  = 0;
        n_checked   = 0;
        n_ok        = 0;
        n_crc       = 0;
        n_to        = 0;
        n_disc      = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        idx     = '0;
        tmr_on  = 1'b0;
        tmr_cnt = 16'h0000;
        crc_lag = CRC_INIT;
    endfunction

    function void write_reg(cfg_reg_t r, logic [15:0] v);
        if (r == REG_EXPECTED_ADDRESS) begin
            addr_cfg = v[7:0];
        end else begin
            ticks_cfg = v;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_input(item_t it);
        result_t     r;
        logic [7:0]  b;
        logic [7:0]  code;
        bit          rd, wr, done;
        int unsigned i;
        r = '0;
        b = it.rx_byte;
        if (it.operation == OP_TICK) begin
            if (tmr_on) begin
                tmr_cnt++;
                if (tmr_cnt >= ticks_cfg) begin
                    clear_frame();
                    to_cnt++;
                    r.status = STAT_TIMEOUT;
                end
            end
        end else begin
            tmr_cnt = 16'h0000;
            tmr_on  = 1'b1;
            if (idx >= RX_BUFFER_BYTES) begin
                clear_frame();
                r.status = STAT_DISCARD;
            end else if (idx == 0 && b != addr_cfg) begin
                r.status = STAT_IDLE;
            end else begin
                i = idx;
                if (i == 0) crc_lag = CRC_INIT;
                if (i < 4) head[i] = b;
                if (i == 4) byte4 = b;
                if (i >= 2) crc_lag = crc16_byte(crc_lag, tail[0]);
                tail[0] = tail[1];
                tail[1] = b;
                idx = 9'(i + 1);
                if (idx > 3) begin
                    code = head[1];
                    rd = code >= FC_READ_COILS && code <= FC_READ_INPUT_REGS;
                    wr = code == FC_WRITE_COIL || code == FC_WRITE_REG
                         || code == FC_WRITE_MULTI;
                    done = (rd && idx > 4 + head[2]) || (wr && idx > 7);
                    if (done) begin
                        r.function_code = code;
                        r.frame_length  = idx;
                        if (crc_lag == {tail[1], tail[0]}) begin
                            r.status = STAT_OK;
                            if (code == FC_READ_COILS || code == FC_READ_INPUTS) begin
                                r.reg_data = {8'h00, head[3]};
                            end else begin
                                r.reg_data = {head[3], byte4};
                            end
                        end else begin
                            r.status = STAT_CRC_ERR;
                            crc_err_cnt++;
                        end
                        clear_frame();
                    end else if (!rd && !wr) begin
                        clear_frame();
                        r.status = STAT_DISCARD;
                    end
                end
            end
        end
        r.crc_errors = crc_err_cnt;
        r.timeouts   = to_cnt;
        case (r.status)
            STAT_OK:      n_ok++;
            STAT_CRC_ERR: n_crc++;
            STAT_TIMEOUT: n_to++;
            STAT_DISCARD: n_disc++;
            default: ;
        endcase
        expected_q.push_back(r);
    endfunction

    function void report(string what, int unsigned e, int unsigned a);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0h, got %0h", what, e, a);
    endfunction

    function void cmp(string what, int unsigned e, int unsigned a);
        if (e != a) report(what, e, a);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] word);
        result_t got, exp;
        got = result_t'(word[TDATA_BITS-1:0]);
        if (expected_q.size() == 0) begin
            report("unexpected word, status", 0, got.status);
            return;
        end
        exp = expected_q.pop_front();
        n_checked++;
        cmp("status", exp.status, got.status);
        cmp("function_code", exp.function_code, got.function_code);
        cmp("reg_data", exp.reg_data, got.reg_data);
        cmp("frame_length", exp.frame_length, got.frame_length);
        cmp("crc_errors", exp.crc_errors, got.crc_errors);
        cmp("timeouts", exp.timeouts, got.timeouts);
    endfunction
endclass

module tb_modbus_rtu_response_receiver;

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 110;
    localparam logic [7:0] UNKNOWN_FC  = 8'hFF;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [0:0]           cfg_index = '0;
    logic [15:0]          cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // rx_byte
    logic                 s_tuser   = 1'b0; // operation
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // status[2:0], function_code[10:3], reg_data[26:11], frame_length[35:27],
    // crc_errors[51:36], timeouts[67:52]
    logic [M_TDATA_W-1:0] m_tdata;

    rx_frame_scoreboard sb = new();

    int         gap_pct     = 0;
    int         stall_pct   = 0;
    int         items_sent  = 0;
    int         cycle_count = 0;
    logic [7:0] frame_buf[$];
    logic [7:0] read_codes[4]  = '{FC_READ_COILS, FC_READ_INPUTS,
                                   FC_READ_HOLDING, FC_READ_INPUT_REGS};
    logic [7:0] write_codes[3] = '{FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_MULTI};

    modbus_rtu_response_receiver uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input({s_tuser, s_tdata});
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // valid stays high after a transfer; the next call or idle_bus decides
    task automatic send_word(op_t op, logic [7:0] b);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic idle_bus();
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.write_reg(r, v);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic void seal_frame();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_buf[k]) c = crc16_byte(c, frame_buf[k]);
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endfunction

    // short silences between bytes stay below the abort limit
    task automatic send_prefix(int cnt);
        int lim;
        lim = (sb.ticks_cfg > 5) ? 4 : int'(sb.ticks_cfg) - 1;
        for (int k = 0; k < cnt; k++) begin
            if (k > 0 && lim > 0 && $urandom_range(9) == 0)
                repeat ($urandom_range(1, lim)) send_word(OP_TICK, 8'($urandom));
            send_word(OP_BYTE, frame_buf[k]);
        end
    endtask

    task automatic make_good(bit rd, int n);
        frame_buf.delete();
        frame_buf.push_back(sb.addr_cfg);
        if (rd) begin
            frame_buf.push_back(read_codes[$urandom_range(3)]);
            frame_buf.push_back(8'(n));
            repeat (n) frame_buf.push_back(8'($urandom));
        end else begin
            frame_buf.push_back(write_codes[$urandom_range(2)]);
            repeat (4) frame_buf.push_back(8'($urandom));
        end
        seal_frame();
    endtask

    task automatic directed();
        send_word(OP_TICK, 8'hFF);
        send_word(OP_BYTE, 8'h00);
        frame_buf = '{sb.addr_cfg, FC_WRITE_REG, 8'hFF, 8'hFF, 8'h00, 8'h00};
        seal_frame();
        send_prefix(frame_buf.size());
        frame_buf = '{sb.addr_cfg, FC_READ_COILS, 8'h00};
        seal_frame();
        send_prefix(frame_buf.size());
        frame_buf = '{sb.addr_cfg, FC_READ_INPUT_REGS, 8'h02, 8'h12, 8'h34};
        seal_frame();
        frame_buf[6] ^= 8'h80;
        send_prefix(frame_buf.size());
        frame_buf = '{sb.addr_cfg, UNKNOWN_FC, 8'h00, 8'h00};
        send_prefix(frame_buf.size());
    endtask

    task automatic random_frame();
        int         kind, n, nt;
        logic [7:0] c;
        kind = $urandom_range(99);
        n = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 7);
        if (kind >= 70 && kind < 84 && sb.ticks_cfg > 40) kind = 0;
        if (kind < 70) begin
            make_good(kind < 35, n);
            if (kind >= 60) begin
                c = 8'(1 << $urandom_range(7));
                frame_buf[$urandom_range(3, frame_buf.size() - 1)] ^= c;
            end
            send_prefix(frame_buf.size());
        end else if (kind < 84) begin
            make_good(kind < 77, n);
            send_prefix($urandom_range(1, frame_buf.size() - 1));
            nt = (sb.ticks_cfg == 0) ? 1 : int'(sb.ticks_cfg);
            repeat (nt) send_word(OP_TICK, 8'($urandom));
        end else if (kind < 90) begin
            do c = 8'($urandom);
            while ((c >= FC_READ_COILS && c <= FC_WRITE_REG) || c == FC_WRITE_MULTI);
            frame_buf = '{sb.addr_cfg, c, 8'($urandom), 8'($urandom)};
            send_prefix(frame_buf.size());
        end else if (kind < 95) begin
            repeat ($urandom_range(1, 3)) begin
                do c = 8'($urandom); while (c == sb.addr_cfg);
                send_word(OP_BYTE, c);
            end
        end else begin
            repeat ($urandom_range(1, 4)) send_word(OP_TICK, 8'($urandom));
        end
    endtask

    task automatic configure(int p);
        case (p)
            1: begin
                write_reg(REG_EXPECTED_ADDRESS, 16'h0000);
                write_reg(REG_INTERCHAR_TICKS, 16'd1);
            end
            2: begin
                write_reg(REG_EXPECTED_ADDRESS, 16'h00FF);
                write_reg(REG_INTERCHAR_TICKS, 16'hFFFF);
            end
            3: begin
                write_reg(REG_EXPECTED_ADDRESS, 16'($urandom_range(255)));
                write_reg(REG_INTERCHAR_TICKS, 16'd0);
            end
            4: begin
                write_reg(REG_EXPECTED_ADDRESS, 16'($urandom_range(255)));
                write_reg(REG_INTERCHAR_TICKS, 16'($urandom_range(2, 20)));
            end
            5: begin
                write_reg(REG_EXPECTED_ADDRESS, 16'h00FF);
                write_reg(REG_INTERCHAR_TICKS, 16'd3);
            end
            6: begin
                write_reg(REG_EXPECTED_ADDRESS, 16'h0000);
                write_reg(REG_INTERCHAR_TICKS, 16'($urandom_range(1, 6)));
            end
            default: begin
                write_reg(REG_EXPECTED_ADDRESS, 16'($urandom_range(255)));
                write_reg(REG_INTERCHAR_TICKS, 16'($urandom_range(1, 40)));
            end
        endcase
    endtask

    initial begin
        int start;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 59; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 59; end
                default: begin gap_pct = 25; stall_pct = 25; end
            endcase
            if (p == 0) begin
                directed();
            end else begin
                configure(p);
            end
            if (p == 3) begin
                // full buffer, then one byte past it
                make_good(1'b1, 0);
                frame_buf = '{sb.addr_cfg, FC_READ_HOLDING, 8'd251};
                repeat (251) frame_buf.push_back(8'($urandom));
                seal_frame();
                send_prefix(frame_buf.size());
                frame_buf = '{sb.addr_cfg, FC_READ_INPUT_REGS, 8'd252};
                repeat (254) frame_buf.push_back(8'($urandom));
                send_prefix(RX_BUFFER_BYTES + 1);
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) random_frame();
            idle_bus();
            drain();
        end
        repeat (10) @(posedge aclk);
        $display("sent %0d words over %0d address/tick settings and four idling patterns",
                 items_sent, PHASES);
        $display("checked %0d results: %0d ok, %0d crc errors, %0d timeouts, %0d discards",
                 sb.n_checked, sb.n_ok, sb.n_crc, sb.n_to, sb.n_disc);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d words outstanding", sb.mismatches, sb.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
